// ===== hw/rtl/fnsp_pkg.sv =====
// Package for the FASTA nucleotide stream parser: counter width, result status
// codes, symbol codes, the result record and small helper functions. No dependencies.
package fnsp_pkg;

  // Width of the internal saturating counters (valid range 8 to 64).
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;
  localparam int unsigned CODE_WIDTH  = 3;

  // Output tdata: 198 bits of fields, padded to 25 bytes.
  localparam int unsigned M_TDATA_WIDTH = 200;
  localparam int unsigned S_TDATA_WIDTH = 8;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [OUT_WIDTH-1:0]   out_word_t;

  localparam cnt_t CNT_MAX  = '1;
  localparam cnt_t CNT_ZERO = '0;
  localparam cnt_t CNT_ONE  = cnt_t'(1);

  typedef enum logic [CODE_WIDTH-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_LETTER   = 3'd1,
    ST_NO_HEADER    = 3'd2,
    ST_NO_SEQUENCE  = 3'd3,
    ST_FIRST_EMPTY  = 3'd4,
    ST_LEN_MISMATCH = 3'd5
  } status_t;

  typedef enum logic [CODE_WIDTH-1:0] {
    SYM_NONE = 3'd0,
    SYM_N    = 3'd1,
    SYM_A    = 3'd2,
    SYM_C    = 3'd3,
    SYM_G    = 3'd4,
    SYM_T    = 3'd5
  } symbol_t;

  typedef enum logic {
    KIND_SYMBOL  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_HEADER  = 8'h3E;  // '>'

  typedef struct packed {
    kind_t     result_kind;
    symbol_t   symbol_code;
    out_word_t seq_index;
    out_word_t position;
    status_t   status;
    out_word_t seq_length;
    out_word_t seq_count;
    out_word_t data_line_count;
    out_word_t bad_sequence;
  } result_t;

  // Map a text byte to its nucleotide code; anything else gives SYM_NONE.
  function automatic symbol_t letter_code(input logic [7:0] b);
    symbol_t code;
    case (b)
      8'h4E, 8'h6E: code = SYM_N;
      8'h41, 8'h61: code = SYM_A;
      8'h43, 8'h63: code = SYM_C;
      8'h47, 8'h67: code = SYM_G;
      8'h54, 8'h74: code = SYM_T;
      default:      code = SYM_NONE;
    endcase
    return code;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  // Low 32 bits of a counter, zero-extended when the counter is narrower.
  function automatic out_word_t to_out(input cnt_t v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[OUT_WIDTH-1:0];
  endfunction

endpackage

// ===== hw/rtl/fasta_nucleotide_stream_parser.sv =====
// Top level of the FASTA nucleotide stream parser: line parser, counters and a
// two-entry output stage. Depends on fnsp_pkg.
//
// The block takes one byte of FASTA text per cycle on the slave stream while s_tready
// is high (s_tlast marks the end of the file; its byte is ignored) and returns at most
// one result per byte. Every accepted byte is fully handled in the cycle it is accepted:
// a compare of the byte and one saturating increment per counter, so the sustained rate
// is one byte per clock while s_tready stays high. Nucleotide letters (N, A, C, G, T in
// either case) come out as symbol results with their sequence index and position; an
// end marker gives a summary with the first sequence length, header count, data-line
// count and status, then the parser returns to its reset state. A bad letter or data
// before any header gives an error report and every further byte is dropped until the
// end marker. Results sit in an output register backed by one skid register. While the
// downstream side stalls, input keeps flowing until one more result has landed in the
// skid register (bytes that give no result do not count); s_tready drops only when both
// are full and rises again the cycle after the output register is taken. Each result
// is registered in the output register, via the skid register on a stall, to m_tdata.
module fasta_nucleotide_stream_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] data_byte
  input  logic [fnsp_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
  input  logic                                s_tlast,   // end_of_stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] symbol_code, [34:3] seq_index, [66:35] position, [69:67] status,
  // [101:70] seq_length, [133:102] seq_count, [165:134] data_line_count,
  // [197:166] bad_sequence, [199:198] zero
  output logic [fnsp_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
  output logic                                m_tuser    // result_kind
);
  import fnsp_pkg::*;

  // Parser state
  logic    at_line_start, at_line_start_next;
  logic    in_header_line, in_header_line_next;
  logic    failed, failed_next;
  status_t fail_code, fail_code_next;
  cnt_t    sequences_seen, sequences_seen_next;
  cnt_t    data_lines_seen, data_lines_seen_next;
  cnt_t    current_length, current_length_next;
  cnt_t    first_length, first_length_next;
  cnt_t    first_mismatch, first_mismatch_next;

  // Output stage
  logic    out_valid, skid_valid;
  result_t out_res, skid_res;

  logic    in_accept;
  logic    has_result;
  result_t new_res;

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;

  always_comb begin
    logic [7:0] b;
    logic       go_letter;
    symbol_t    code;
    status_t    st;
    cnt_t       fl_closed;
    cnt_t       mm_closed;

    b         = s_tdata[7:0];
    go_letter = 1'b0;
    code      = SYM_NONE;
    st        = ST_OK;

    // Effect of closing the open sequence, used on a header and at the end marker.
    fl_closed = first_length;
    mm_closed = first_mismatch;
    if (sequences_seen == CNT_ONE) begin
      fl_closed = current_length;
    end else if (sequences_seen > CNT_ONE && current_length != first_length &&
                 first_mismatch == CNT_ZERO) begin
      mm_closed = sequences_seen;
    end

    at_line_start_next   = at_line_start;
    in_header_line_next  = in_header_line;
    failed_next          = failed;
    fail_code_next       = fail_code;
    sequences_seen_next  = sequences_seen;
    data_lines_seen_next = data_lines_seen;
    current_length_next  = current_length;
    first_length_next    = first_length;
    first_mismatch_next  = first_mismatch;

    has_result              = 1'b0;
    new_res.result_kind     = KIND_SUMMARY;
    new_res.symbol_code     = SYM_NONE;
    new_res.seq_index       = '0;
    new_res.position        = '0;
    new_res.status          = ST_OK;
    new_res.seq_length      = to_out(first_length);
    new_res.seq_count       = to_out(sequences_seen);
    new_res.data_line_count = to_out(data_lines_seen);
    new_res.bad_sequence    = to_out(first_mismatch);

    if (s_tlast) begin
      // End of file: report, then return to the reset state.
      has_result = 1'b1;
      if (failed) begin
        st = fail_code;
      end else begin
        new_res.seq_length   = to_out(fl_closed);
        new_res.bad_sequence = to_out(mm_closed);
        if (sequences_seen == CNT_ZERO) begin
          st = ST_NO_SEQUENCE;
        end else if (fl_closed == CNT_ZERO) begin
          st = ST_FIRST_EMPTY;
        end else if (mm_closed != CNT_ZERO) begin
          st = ST_LEN_MISMATCH;
        end
      end
      new_res.status       = st;
      at_line_start_next   = 1'b1;
      in_header_line_next  = 1'b0;
      failed_next          = 1'b0;
      fail_code_next       = ST_OK;
      sequences_seen_next  = CNT_ZERO;
      data_lines_seen_next = CNT_ZERO;
      current_length_next  = CNT_ZERO;
      first_length_next    = CNT_ZERO;
      first_mismatch_next  = CNT_ZERO;
    end else if (!failed) begin
      if (b == CHAR_NEWLINE) begin
        at_line_start_next  = 1'b1;
        in_header_line_next = 1'b0;
      end else begin
        if (at_line_start) begin
          at_line_start_next = 1'b0;
          if (b == CHAR_HEADER) begin
            // Open a new sequence; the rest of the header line is dropped.
            first_length_next   = fl_closed;
            first_mismatch_next = mm_closed;
            sequences_seen_next = sat_inc(sequences_seen);
            current_length_next = CNT_ZERO;
            in_header_line_next = 1'b1;
          end else if (sequences_seen == CNT_ZERO) begin
            has_result     = 1'b1;
            failed_next    = 1'b1;
            fail_code_next = ST_NO_HEADER;
            new_res.status = ST_NO_HEADER;
            new_res.position = to_out(current_length);
          end else begin
            data_lines_seen_next = sat_inc(data_lines_seen);
            go_letter            = 1'b1;
          end
        end else if (!in_header_line) begin
          go_letter = 1'b1;
        end

        if (go_letter) begin
          code                    = letter_code(b);
          has_result              = 1'b1;
          new_res.data_line_count = to_out(data_lines_seen_next);
          new_res.position        = to_out(current_length);
          // Here sequences_seen is at least one.
          new_res.seq_index       = to_out(sequences_seen - CNT_ONE);
          if (code == SYM_NONE) begin
            failed_next    = 1'b1;
            fail_code_next = ST_BAD_LETTER;
            new_res.status = ST_BAD_LETTER;
          end else begin
            new_res.result_kind = KIND_SYMBOL;
            new_res.symbol_code = code;
            current_length_next = sat_inc(current_length);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start   <= 1'b1;
      in_header_line  <= 1'b0;
      failed          <= 1'b0;
      fail_code       <= ST_OK;
      sequences_seen  <= CNT_ZERO;
      data_lines_seen <= CNT_ZERO;
      current_length  <= CNT_ZERO;
      first_length    <= CNT_ZERO;
      first_mismatch  <= CNT_ZERO;
    end else if (in_accept) begin
      at_line_start   <= at_line_start_next;
      in_header_line  <= in_header_line_next;
      failed          <= failed_next;
      fail_code       <= fail_code_next;
      sequences_seen  <= sequences_seen_next;
      data_lines_seen <= data_lines_seen_next;
      current_length  <= current_length_next;
      first_length    <= first_length_next;
      first_mismatch  <= first_mismatch_next;
    end
  end

  // Output register plus skid register. While the output is stalled a new result
  // lands in the skid register; once the output frees up the skid drains first,
  // which keeps results in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (in_accept && has_result) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !m_tready) begin
      if (in_accept && has_result) begin
        skid_res <= new_res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (in_accept && has_result) begin
      out_res <= new_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.result_kind;
  assign m_tdata  = {2'b00,
                     out_res.bad_sequence,
                     out_res.data_line_count,
                     out_res.seq_count,
                     out_res.seq_length,
                     out_res.status,
                     out_res.position,
                     out_res.seq_index,
                     out_res.symbol_code};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for fasta_nucleotide_stream_parser: a byte-level predictor in a
// small scoreboard class, directed and random FASTA text with stalls on both streams.
// Depends on fnsp_pkg and the parser RTL.

import fnsp_pkg::*;

// Field offsets in the result tdata, lowest field first.
localparam int unsigned OFS_INDEX  = CODE_WIDTH;
localparam int unsigned OFS_POS    = OFS_INDEX + OUT_WIDTH;
localparam int unsigned OFS_STATUS = OFS_POS + OUT_WIDTH;
localparam int unsigned OFS_LENGTH = OFS_STATUS + CODE_WIDTH;
localparam int unsigned OFS_COUNT  = OFS_LENGTH + OUT_WIDTH;
localparam int unsigned OFS_LINES  = OFS_COUNT + OUT_WIDTH;
localparam int unsigned OFS_BAD    = OFS_LINES + OUT_WIDTH;

localparam logic [7:0] CHAR_CR = 8'd13;

// Nucleotide code of a text byte, either case; SYM_NONE for anything else.
function automatic symbol_t nuc_code(input logic [7:0] b);
  case (b)
    "N", "n": return SYM_N;
    "A", "a": return SYM_A;
    "C", "c": return SYM_C;
    "G", "g": return SYM_G;
    "T", "t": return SYM_T;
    default:  return SYM_NONE;
  endcase
endfunction

class fasta_scoreboard;
  cnt_t    seqs, dlines, cur_len, first_len, first_mis;
  bit      at_start, in_header, failed;
  status_t fail_st;
  result_t expected_q[$];
  int      errors, n_symbols, n_reports;

  function new();
    clear_state();
  endfunction

  function void clear_state();
    at_start  = 1'b1;
    in_header = 1'b0;
    seqs      = CNT_ZERO;
    dlines    = CNT_ZERO;
    cur_len   = CNT_ZERO;
    first_len = CNT_ZERO;
    first_mis = CNT_ZERO;
    failed    = 1'b0;
    fail_st   = ST_OK;
  endfunction

  function cnt_t bump(cnt_t v);
    return (v == CNT_MAX) ? v : v + CNT_ONE;
  endfunction

  // Record the length of the open sequence: the first sets the reference.
  function void close_seq();
    if (seqs == CNT_ONE)
      first_len = cur_len;
    else if (seqs != CNT_ZERO && cur_len != first_len && first_mis == CNT_ZERO)
      first_mis = seqs;
  endfunction

  function void queue_result(kind_t k, symbol_t code, cnt_t idx, cnt_t pos, status_t st);
    result_t r;
    r.result_kind     = k;
    r.symbol_code     = code;
    r.seq_index       = out_word_t'(idx);
    r.position        = out_word_t'(pos);
    r.status          = st;
    r.seq_length      = out_word_t'(first_len);
    r.seq_count       = out_word_t'(seqs);
    r.data_line_count = out_word_t'(dlines);
    r.bad_sequence    = out_word_t'(first_mis);
    expected_q.push_back(r);
    if (k == KIND_SYMBOL) n_symbols++;
    else n_reports++;
  endfunction

  function void flag_error(status_t st);
    failed  = 1'b1;
    fail_st = st;
    queue_result(KIND_SUMMARY, SYM_NONE, (seqs != CNT_ZERO) ? seqs - CNT_ONE : CNT_ZERO,
                 cur_len, st);
  endfunction

  // Advance the parser state by one accepted input transaction.
  function void note_input(logic [7:0] b, logic eof);
    status_t st;
    symbol_t code;
    if (eof) begin
      if (failed) begin
        st = fail_st;
      end else begin
        close_seq();
        if (seqs == CNT_ZERO) st = ST_NO_SEQUENCE;
        else if (first_len == CNT_ZERO) st = ST_FIRST_EMPTY;
        else if (first_mis != CNT_ZERO) st = ST_LEN_MISMATCH;
        else st = ST_OK;
      end
      queue_result(KIND_SUMMARY, SYM_NONE, CNT_ZERO, CNT_ZERO, st);
      clear_state();
      return;
    end
    if (failed) return;
    if (b == CHAR_NEWLINE) begin
      at_start  = 1'b1;
      in_header = 1'b0;
      return;
    end
    if (at_start) begin
      at_start = 1'b0;
      if (b == CHAR_HEADER) begin
        close_seq();
        seqs      = bump(seqs);
        cur_len   = CNT_ZERO;
        in_header = 1'b1;
        return;
      end
      if (seqs == CNT_ZERO) begin
        flag_error(ST_NO_HEADER);
        return;
      end
      dlines = bump(dlines);
    end else if (in_header) begin
      return;
    end
    code = nuc_code(b);
    if (code == SYM_NONE) begin
      flag_error(ST_BAD_LETTER);
      return;
    end
    queue_result(KIND_SYMBOL, code, seqs - CNT_ONE, cur_len, ST_OK);
    cur_len = bump(cur_len);
  endfunction

  function void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare one output transaction with the oldest expectation.
  function void check_result(logic [M_TDATA_WIDTH-1:0] d, logic u);
    result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual tuser=%0d tdata=%h",
               $time, u, d);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    check_field("result_kind", e.result_kind, u);
    check_field("symbol_code", e.symbol_code, d[CODE_WIDTH-1:0]);
    check_field("seq_index", e.seq_index, d[OFS_INDEX +: OUT_WIDTH]);
    check_field("position", e.position, d[OFS_POS +: OUT_WIDTH]);
    check_field("status", e.status, d[OFS_STATUS +: CODE_WIDTH]);
    check_field("seq_length", e.seq_length, d[OFS_LENGTH +: OUT_WIDTH]);
    check_field("seq_count", e.seq_count, d[OFS_COUNT +: OUT_WIDTH]);
    check_field("data_line_count", e.data_line_count, d[OFS_LINES +: OUT_WIDTH]);
    check_field("bad_sequence", e.bad_sequence, d[OFS_BAD +: OUT_WIDTH]);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;

  typedef struct {
    logic [7:0] b;
    bit         eof;
    bit         drain;   // wait for every expected result before offering this byte
  } text_item_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC, RX_HOLD} rx_mode_t;

  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 120;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
  logic                     s_tlast = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [M_TDATA_WIDTH-1:0] m_tdata;
  logic                     m_tuser;

  fasta_scoreboard sb = new();
  text_item_t      text_q[$];
  bit              drain_next;
  bit              spoiled;      // the current file hit an error; later bytes are dropped
  int              live_items;
  int              n_files;

  fasta_nucleotide_stream_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  task automatic push_byte(logic [7:0] b);
    text_q.push_back('{b: b, eof: 1'b0, drain: drain_next});
    drain_next = 1'b0;
    if (!spoiled) live_items++;
  endtask

  task automatic push_text(string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  // Close the file; the byte beside the end marker is junk.
  task automatic push_end();
    text_q.push_back('{b: 8'($urandom_range(0, 255)), eof: 1'b1, drain: drain_next});
    drain_next = 1'b0;
    n_files++;
  endtask

  function automatic logic [7:0] random_letter();
    string letters = "NACGTnacgt";
    return letters[$urandom_range(0, 9)];
  endfunction

  // One random file: mostly well-formed FASTA, sometimes with a fault, sometimes noise.
  task automatic gen_file();
    int         nseq, base_len, seq_len, line_len, bad_at, letter_no, s;
    bit         no_final_lf;
    logic [7:0] b;
    spoiled = 1'b0;
    if ($urandom_range(0, 5) == 0) drain_next = 1'b1;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 16)) push_byte(8'($urandom_range(0, 255)));
      push_end();
      return;
    end
    nseq        = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    base_len    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
    bad_at      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nseq * base_len + 2) : -1;
    no_final_lf = $urandom_range(0, 1);
    letter_no   = 0;
    // Data ahead of any header is rare.
    if ($urandom_range(0, 19) == 0) begin
      push_byte(random_letter());
      spoiled = 1'b1;
      push_byte(CHAR_NEWLINE);
    end
    for (s = 0; s < nseq; s++) begin
      while ($urandom_range(0, 4) == 0) push_byte(CHAR_NEWLINE);
      push_byte(CHAR_HEADER);
      repeat ($urandom_range(0, 5)) begin
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_NEWLINE);
        push_byte(b);
      end
      seq_len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12) : base_len;
      if (s == nseq - 1 && seq_len == 0 && no_final_lf) continue;
      push_byte(CHAR_NEWLINE);
      while (seq_len > 0) begin
        line_len = $urandom_range(1, 6);
        if (line_len > seq_len) line_len = seq_len;
        repeat (line_len) begin
          if (letter_no == bad_at) begin
            if ($urandom_range(0, 2) == 0) begin
              b = CHAR_CR;
            end else begin
              do b = 8'($urandom_range(0, 255));
              while (nuc_code(b) != SYM_NONE || b == CHAR_NEWLINE || b == CHAR_HEADER);
            end
            push_byte(b);
            spoiled = 1'b1;
          end else begin
            push_byte(random_letter());
          end
          letter_no++;
        end
        seq_len -= line_len;
        if (!(s == nseq - 1 && seq_len == 0 && no_final_lf)) push_byte(CHAR_NEWLINE);
      end
    end
    push_end();
  endtask

  // Check every output transaction against the predictor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Receiver: stretches of different stall patterns, one long hold-off early in the run.
  initial begin
    rx_mode_t mode;
    int       span, cyc;
    bit       held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 80);
      if (!held && cyc > 150) begin
        mode = RX_HOLD;
        span = HOLD_CYCLES;
        held = 1'b1;
      end
      repeat (span) begin
        @(posedge clk);
        cyc++;
        case (mode)
          RX_OPEN:     m_tready <= 1'b1;
          RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   m_tready <= ($urandom_range(0, 7) == 0);
          RX_PERIODIC: m_tready <= (cyc % 3 != 0);
          default:     m_tready <= 1'b0;
        endcase
      end
    end
  end

  // Sender: build the text, release reset, then offer bytes in bursts.
  initial begin
    int burst_left, idx;
    drain_next = 1'b0;
    spoiled    = 1'b0;
    live_items = 0;
    n_files    = 0;

    // Directed files: no sequence, data before header (on a byte that is also a bad
    // letter), empty first sequence, empty line plus mismatch with an unterminated
    // last line, bad byte 0 after a header holding 255, carriage return on a data line.
    push_end();
    push_text("x");
    push_end();
    push_text(">");
    push_end();
    push_text("\n>\nNACGT\n>\nt");
    push_end();
    push_byte(CHAR_HEADER);
    push_byte(8'hFF);
    push_byte(CHAR_NEWLINE);
    push_byte(8'h00);
    push_text("A");
    push_end();
    push_text(">\nA");
    push_byte(CHAR_CR);
    push_end();

    live_items = 0;
    drain_next = 1'b1;
    while (live_items < RANDOM_ITEMS) gen_file();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    burst_left = $urandom_range(1, 24);
    for (idx = 0; idx < text_q.size(); idx++) begin
      if (idx != 0 && burst_left == 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom_range(0, 255));
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end
      // Hold off until the block has delivered everything it owes.
      if (text_q[idx].drain && sb.pending() != 0) begin
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= text_q[idx].b;
      s_tlast  <= text_q[idx].eof;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      sb.note_input(text_q[idx].b, text_q[idx].eof);
      burst_left--;
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // Let any stray result show up.
    repeat (8) @(posedge clk);

    $display("Covered %0d files in %0d bytes: %0d symbols and %0d summaries or error reports.",
             n_files, text_q.size(), sb.n_symbols, sb.n_reports);
    $display("Mismatches found: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== fasta_nucleotide_stream_parser.f =====
hw/rtl/fnsp_pkg.sv
hw/rtl/fasta_nucleotide_stream_parser.sv
dv/testbench.sv
